### design/sliding_window_average_top_assert.svh
// Assertion macros for the sliding window average block.
// Used by the port-level checker; expects clk and rst_n in scope.
`ifndef SLIDING_WINDOW_AVERAGE_TOP_ASSERT_SVH
`define SLIDING_WINDOW_AVERAGE_TOP_ASSERT_SVH

// antecedent and consequent in the same cycle
`define SWA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define SWA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/swa_pkg.sv
// Shared constants, types and controller/datapath interface structs for the
// sliding window average block. No dependencies.
`default_nettype none

package swa_pkg;

  localparam int WINDOW_MAX  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_BITS    = 6;
  localparam int PTR_BITS    = $clog2(WINDOW_MAX);
  localparam int LEN_BITS    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_BITS    = SAMPLE_BITS + PTR_BITS;
  localparam int DIV_STEPS   = SUM_BITS;
  localparam int DCNT_BITS   = $clog2(DIV_STEPS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // take input beat, write delay line
    logic issue;     // read one delay-line entry
    logic div_init;  // load divider from window sum
    logic div_step;  // one quotient bit
    logic load_out;  // move quotient to output register
  } swa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fill_ok;   // accepted sample completes a window
    logic rd_last;   // last entry of the window being read
    logic div_last;  // last quotient bit
    logic out_free;  // output register can take a result
  } swa_stat_t;

endpackage

`default_nettype wire

### design/sliding_window_average_top.sv
// Sliding window average: each input beat carries one Q7.8 sample; once the
// current set holds at least window_length samples, each beat yields the mean
// of the newest window_length samples, truncated toward zero. A beat that
// completes no window does not hold in_stall. A beat with a result holds
// in_stall after acceptance while the delay-line memory gives one entry per
// cycle to the accumulator and then a bit-serial divider finds the quotient
// one bit at a time. The result sits in an output register, so the next beat
// is taken while it waits; the block only waits on out_stall if a second
// result is ready before the first is taken.
// Depends on swa_pkg, swa_ctrl and swa_datapath.
`default_nettype none

module sliding_window_average_top import swa_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                   in_start_of_set,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [SAMPLE_BITS-1:0]      out_average,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_BITS-1:0]    cfg_wdata
);

  swa_cmd_t  cmd;
  swa_stat_t stat;

  swa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  swa_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_sample       (in_sample),
    .in_start_of_set (in_start_of_set),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_average     (out_average)
  );

endmodule

`default_nettype wire

### design/swa_datapath.sv
// Datapath: delay-line memory, fill and window length registers, window
// accumulator, bit-serial divider and output register. Uses swa_pkg.
`default_nettype none

module swa_datapath import swa_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                in_start_of_set,
  input  wire logic                cfg_we,
  input  wire logic [CFG_BITS-1:0] cfg_wdata,
  input  wire swa_cmd_t            cmd,
  output swa_stat_t                stat,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [SAMPLE_BITS-1:0]   out_average
);

  logic [SAMPLE_BITS-1:0] hist_mem [WINDOW_MAX];

  logic [LEN_BITS-1:0]    wlen_r, wlen_nxt;
  logic [LEN_BITS-1:0]    fill_r, fill_nxt;
  logic [PTR_BITS-1:0]    wp_r;
  logic [PTR_BITS-1:0]    rd_ptr_r;
  logic [LEN_BITS-1:0]    rd_cnt_r;
  logic                   rd_valid_r;
  sample_t                rd_data_r;
  sum_t                   acc_r;
  logic [SUM_BITS-1:0]    quo_r;
  logic [LEN_BITS-1:0]    rem_r;
  logic                   neg_r;
  logic [DCNT_BITS-1:0]   dcnt_r;
  logic [LEN_BITS+1:0]    trial;
  logic [SUM_BITS-1:0]    mean_w;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_average_r;

  // register write: zero reads as one, large values saturate
  always_comb begin
    priority if (cfg_wdata == '0) begin
      wlen_nxt = LEN_BITS'(1);
    end else if (int'(cfg_wdata) > WINDOW_MAX) begin
      wlen_nxt = LEN_BITS'(WINDOW_MAX);
    end else begin
      wlen_nxt = LEN_BITS'(cfg_wdata);
    end
  end

  always_comb begin
    priority if (in_start_of_set) begin
      fill_nxt = LEN_BITS'(1);
    end else if (fill_r == LEN_BITS'(WINDOW_MAX)) begin
      fill_nxt = fill_r;
    end else begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r     <= LEN_BITS'(1);
      fill_r     <= '0;
      wp_r       <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        wlen_r <= wlen_nxt;
      end
      if (cmd.accept) begin
        fill_r <= fill_nxt;
        wp_r   <= (wp_r == PTR_BITS'(WINDOW_MAX - 1)) ? '0 : wp_r + 1'b1;
      end
      rd_valid_r <= cmd.issue;
    end
  end

  // delay line; write only on accept, reads only while walking the window
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hist_mem[wp_r] <= in_sample;
    end
    if (cmd.issue) begin
      rd_data_r <= hist_mem[rd_ptr_r];
    end
  end

  // walk backward from the newest entry
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_ptr_r <= wp_r;
      rd_cnt_r <= wlen_r;
    end else if (cmd.issue) begin
      rd_ptr_r <= (rd_ptr_r == '0) ? PTR_BITS'(WINDOW_MAX - 1) : rd_ptr_r - 1'b1;
      rd_cnt_r <= rd_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      acc_r <= '0;
    end else if (rd_valid_r) begin
      acc_r <= acc_r + sum_t'(rd_data_r);
    end
  end

  // restoring divide of |sum| by window length, one bit per cycle
  assign trial = {1'b0, rem_r, quo_r[SUM_BITS-1]} - {2'b00, wlen_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg_r  <= acc_r[SUM_BITS-1];
      quo_r  <= acc_r[SUM_BITS-1] ? SUM_BITS'(-acc_r) : SUM_BITS'(acc_r);
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
      if (!trial[LEN_BITS+1]) begin
        rem_r <= trial[LEN_BITS-1:0];
        quo_r <= {quo_r[SUM_BITS-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[LEN_BITS-2:0], quo_r[SUM_BITS-1]};
        quo_r <= {quo_r[SUM_BITS-2:0], 1'b0};
      end
    end
  end

  assign mean_w = neg_r ? (~quo_r + 1'b1) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_average_r <= mean_w[SAMPLE_BITS-1:0];
    end
  end

  assign stat.fill_ok  = (fill_nxt >= wlen_r);
  assign stat.rd_last  = (rd_cnt_r == LEN_BITS'(1));
  assign stat.div_last = (dcnt_r == DCNT_BITS'(DIV_STEPS - 1));
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

endmodule

`default_nettype wire

### design/swa_ctrl.sv
// Controller: sequences accept, window read, divide and result hand-off.
// Uses swa_pkg for the command and status structs.
`default_nettype none

module swa_ctrl import swa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire swa_stat_t stat,
  output swa_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;  // last read data lands in the sum
  localparam logic [2:0] S_INIT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.fill_ok) begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.issue = 1'b1;
        if (stat.rd_last) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

### design/swa_checker.sv
// Port-level checker for sliding_window_average_top, bound to the top level.
// Uses the macros in sliding_window_average_top_assert.svh and swa_pkg.
`default_nettype none

`include "sliding_window_average_top_assert.svh"

module swa_checker import swa_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [SAMPLE_BITS-1:0] out_average
);

  `SWA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped")
  `SWA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_average), "stalled result changed")
  // a result never shows up right behind the beat that caused it
  `SWA_ASSERT_NEXT(a_min_latency, in_valid && !in_stall, !$rose(out_valid), "result too early")
  // results are loaded only while the input side is held off
  `SWA_ASSERT_SAME(a_load_busy, $rose(out_valid), $past(in_stall), "result loaded while idle")

endmodule

bind sliding_window_average_top swa_checker u_swa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_average (out_average)
);

`default_nettype wire
